### design/hsms_pkg.sv
`timescale 1ns / 1ps

package hsms_pkg;

	// Field widths of the channels and registers.
	localparam int OP_W        = 4;
	localparam int CELSIUS_W   = 10;
	localparam int SETPOINT_W  = 12;
	localparam int MODE_W      = 2;
	localparam int GAIN_W      = 16;
	localparam int DELAY_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Gain is Q4.12; the setpoint product carries one extra half-degree bit.
	localparam int GAIN_FRAC_W = 12;
	localparam int FRAC_SHIFT  = GAIN_FRAC_W + 1;
	localparam int STEP_W      = $clog2(CELSIUS_W + 1);

	localparam int unsigned ADC_MAX_DEF         = 4095;
	localparam int unsigned TICKS_PER_COUNT_DEF = 11;

	// Event codes.
	localparam logic [OP_W-1:0] OP_TICK         = 4'd0;
	localparam logic [OP_W-1:0] OP_ON           = 4'd1;
	localparam logic [OP_W-1:0] OP_OFF          = 4'd2;
	localparam logic [OP_W-1:0] OP_MANUAL       = 4'd3;
	localparam logic [OP_W-1:0] OP_PRESET1      = 4'd4;
	localparam logic [OP_W-1:0] OP_PRESET2      = 4'd5;
	localparam logic [OP_W-1:0] OP_BOOST_ON     = 4'd6;
	localparam logic [OP_W-1:0] OP_BOOST_OFF    = 4'd7;
	localparam logic [OP_W-1:0] OP_MOTION       = 4'd8;
	localparam logic [OP_W-1:0] OP_WRITE_MANUAL = 4'd9;

	// Working modes.
	localparam logic [MODE_W-1:0] MODE_MANUAL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PRESET1 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRESET2 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SLEEP   = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET_ONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET_TWO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TEMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY   = 3'd5;

	// Register reset values.
	localparam logic [GAIN_W-1:0]    GAIN_RST        = 16'd32768;
	localparam logic [CELSIUS_W-1:0] PRESET_ONE_RST  = 10'd250;
	localparam logic [CELSIUS_W-1:0] PRESET_TWO_RST  = 10'd350;
	localparam logic [CELSIUS_W-1:0] SLEEP_TEMP_RST  = 10'd150;
	localparam logic [DELAY_W-1:0]   SLEEP_DELAY_RST = 16'd300;
	localparam logic [DELAY_W-1:0]   OFF_DELAY_RST   = 16'd600;
	localparam logic [CELSIUS_W-1:0] MANUAL_RST      = 10'd300;

	// Setpoint request and response between sequencer and arithmetic unit.
	typedef struct packed {
		logic                 start;
		logic                 boost;
		logic [CELSIUS_W-1:0] celsius;
	} sp_req_t;

	typedef struct packed {
		logic                  done;
		logic                  clamped;
		logic [SETPOINT_W-1:0] adc;
		logic [CELSIUS_W-1:0]  celsius;
	} sp_rsp_t;

endpackage

### design/hsms_if.sv
`timescale 1ns / 1ps

interface hsms_item_if;
	import hsms_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic                 motion_level;
	logic [CELSIUS_W-1:0] manual_value;

	modport source (output valid, output op, output motion_level, output manual_value,
		input ready);
	modport sink (input valid, input op, input motion_level, input manual_value,
		output ready);
endinterface

interface hsms_result_if;
	import hsms_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [SETPOINT_W-1:0] setpoint_adc;
	logic [CELSIUS_W-1:0]  setpoint_celsius;
	logic [MODE_W-1:0]     active_mode;
	logic                  heater_enabled;
	logic                  boost_active;
	logic                  controller_restart;

	modport source (output valid, output setpoint_adc, output setpoint_celsius,
		output active_mode, output heater_enabled, output boost_active,
		output controller_restart, input ready);
	modport sink (input valid, input setpoint_adc, input setpoint_celsius,
		input active_mode, input heater_enabled, input boost_active,
		input controller_restart, output ready);
endinterface

interface hsms_cfg_if;
	import hsms_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### design/hsms_setpoint.sv
`timescale 1ns / 1ps

module hsms_setpoint #(
	parameter int unsigned ADC_MAX = hsms_pkg::ADC_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hsms_pkg::GAIN_W-1:0] gain,
	input  hsms_pkg::sp_req_t           req,
	output hsms_pkg::sp_rsp_t           rsp
);
	import hsms_pkg::*;

	localparam int ADC_W  = $clog2(ADC_MAX + 1);
	localparam int NUM_W  = ADC_W + GAIN_FRAC_W;
	localparam int DVS_W  = GAIN_W + CELSIUS_W;
	localparam int OPW    = (NUM_W > DVS_W) ? NUM_W : DVS_W;
	localparam int PROD_W = CELSIUS_W + 1 + GAIN_W;

	localparam logic [OPW-1:0]        NUM     = OPW'(ADC_MAX) << GAIN_FRAC_W;
	localparam logic [OPW-1:0]        ADC_LIM = OPW'(ADC_MAX);
	localparam logic [SETPOINT_W-1:0] ADC_OUT = SETPOINT_W'(ADC_MAX);

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_DIV} sp_state_t;

	sp_state_t             state_q;
	logic [PROD_W-1:0]     prod_q;
	logic [OPW-1:0]        rem_q;
	logic [OPW-1:0]        dvs_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [CELSIUS_W-1:0]  quot_q;
	logic [CELSIUS_W-1:0]  cel_q;
	sp_rsp_t               rsp_q;

	logic [OPW-1:0] opa;
	logic [OPW-1:0] opb;
	logic [OPW:0]   diff;
	logic           ge;

	// The one subtract-compare unit: clamp test against ADC_MAX, and each
	// restoring division step of the boost temperature.
	always_comb begin
		case (state_q)
			S_DIV: begin
				opa = rem_q;
				opb = dvs_q;
			end
			default: begin
				opa = OPW'(prod_q[PROD_W-1:FRAC_SHIFT]);
				opb = ADC_LIM;
			end
		endcase
		diff = {1'b0, opa} - {1'b0, opb};
		ge   = ~diff[OPW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						cel_q <= req.celsius;
						if (req.boost) begin
							rem_q   <= NUM;
							dvs_q   <= OPW'(gain) << CELSIUS_W;
							cnt_q   <= STEP_W'(CELSIUS_W);
							quot_q  <= '0;
							state_q <= S_DIV;
						end else begin
							prod_q  <= PROD_W'({req.celsius, 1'b1}) * PROD_W'(gain);
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					rsp_q.done    <= 1'b1;
					rsp_q.clamped <= ge;
					rsp_q.adc     <= ge ? ADC_OUT
						: prod_q[FRAC_SHIFT+SETPOINT_W-1:FRAC_SHIFT];
					rsp_q.celsius <= cel_q;
					state_q       <= S_IDLE;
				end
				S_DIV: begin
					if (ge) begin
						rem_q <= diff[OPW-1:0];
					end
					dvs_q <= dvs_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					// The first step only checks whether the quotient overflows
					// ten bits; a zero gain always does.
					if (cnt_q == STEP_W'(CELSIUS_W)) begin
						if (ge) begin
							rsp_q.done    <= 1'b1;
							rsp_q.clamped <= 1'b0;
							rsp_q.adc     <= ADC_OUT;
							rsp_q.celsius <= '1;
							state_q       <= S_IDLE;
						end
					end else begin
						quot_q <= {quot_q[CELSIUS_W-2:0], ge};
						if (cnt_q == '0) begin
							rsp_q.done    <= 1'b1;
							rsp_q.clamped <= 1'b0;
							rsp_q.adc     <= ADC_OUT;
							rsp_q.celsius <= {quot_q[CELSIUS_W-2:0], ge};
							state_q       <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

### design/heater_sleep_and_mode_supervisor.sv
`timescale 1ns / 1ps

// Channel      Direction  Handshake     Payload
// cfg          in         valid/ready   index, data (register write)
// item_in      in         valid/ready   op, motion_level, manual_value
// result_out   out        valid/ready   setpoint_adc, setpoint_celsius, active_mode,
//                                       heater_enabled, boost_active, controller_restart
//
// One event at a time: S_IDLE takes it, S_EXEC decodes it, S_APPLY waits for a
// recomputed setpoint, and S_FINISH loads the output register. With boost on, the shared
// subtract-compare unit runs an overflow check and, if none, ten restoring division steps.
// Reset clears mode, timer and handshake state and loads register defaults;
// register writes are accepted in every cycle. A finished result waits in the output
// register while the next event is taken; a second one waits in the sequencer.
module heater_sleep_and_mode_supervisor #(
	parameter int unsigned ADC_MAX         = hsms_pkg::ADC_MAX_DEF,
	parameter int unsigned TICKS_PER_COUNT = hsms_pkg::TICKS_PER_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hsms_cfg_if.sink      cfg,
	hsms_item_if.sink     item_in,
	hsms_result_if.source result_out
);
	import hsms_pkg::*;

	localparam int DIV_W = (TICKS_PER_COUNT > 1) ? $clog2(TICKS_PER_COUNT) : 1;
	localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(TICKS_PER_COUNT - 1);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_APPLY, S_FINISH} seq_state_t;

	seq_state_t state_q;

	logic [GAIN_W-1:0]    gain_q;
	logic [CELSIUS_W-1:0] preset_one_q;
	logic [CELSIUS_W-1:0] preset_two_q;
	logic [CELSIUS_W-1:0] sleep_temp_q;
	logic [DELAY_W-1:0]   sleep_delay_q;
	logic [DELAY_W-1:0]   off_delay_q;

	logic [OP_W-1:0]      op_q;
	logic                 level_q;
	logic [CELSIUS_W-1:0] value_q;

	logic [MODE_W-1:0]     mode_q;
	logic [MODE_W-1:0]     mode_before_sleep_q;
	logic [DELAY_W-1:0]    idle_q;
	logic [DIV_W-1:0]      div_q;
	logic [CELSIUS_W-1:0]  manual_q;
	logic [CELSIUS_W-1:0]  last_good_q;
	logic                  iron_q;
	logic                  boost_q;
	logic                  motion_q;
	logic [SETPOINT_W-1:0] target_adc_q;
	logic [CELSIUS_W-1:0]  target_cel_q;
	logic                  restart_q;
	logic                  post_wake_q;
	sp_req_t               req_q;
	sp_rsp_t               rsp;

	logic                  out_valid_q;
	logic [SETPOINT_W-1:0] out_adc_q;
	logic [CELSIUS_W-1:0]  out_cel_q;
	logic [MODE_W-1:0]     out_mode_q;
	logic                  out_heater_q;
	logic                  out_boost_q;
	logic                  out_restart_q;

	logic [MODE_W-1:0]  wake_mode;
	logic               manual_diff;
	logic [DELAY_W-1:0] idle_inc;
	logic [DELAY_W:0]   off_sum;
	logic               hit_sleep;
	logic               hit_off;
	logic               tick_roll;
	logic               off_now;

	function automatic logic [CELSIUS_W-1:0] temp_for(
		input logic [MODE_W-1:0]    m,
		input logic [CELSIUS_W-1:0] man,
		input logic [CELSIUS_W-1:0] p1,
		input logic [CELSIUS_W-1:0] p2,
		input logic [CELSIUS_W-1:0] slp
	);
		logic [CELSIUS_W-1:0] t;
		case (m)
			MODE_MANUAL:  t = man;
			MODE_PRESET1: t = p1;
			MODE_PRESET2: t = p2;
			default:      t = slp;
		endcase
		return t;
	endfunction

	assign wake_mode   = (mode_q == MODE_SLEEP) ? mode_before_sleep_q : mode_q;
	assign manual_diff = (last_good_q != manual_q);
	assign idle_inc    = idle_q + 1'b1;
	// The turn-off point is a 17-bit sum, so a sum past 16 bits never matches.
	assign off_sum     = {1'b0, sleep_delay_q} + {1'b0, off_delay_q};
	assign hit_sleep   = (idle_q == sleep_delay_q);
	assign hit_off     = ({1'b0, idle_inc} == off_sum);
	assign tick_roll   = (div_q == DIV_LAST);
	assign off_now     = (op_q == OP_OFF)
		|| ((op_q == OP_TICK) && tick_roll && iron_q && !hit_sleep && hit_off);

	hsms_setpoint #(
		.ADC_MAX(ADC_MAX)
	) u_setpoint (
		.clk    (clk),
		.arst_n (arst_n),
		.gain   (gain_q),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RST;
			preset_one_q  <= PRESET_ONE_RST;
			preset_two_q  <= PRESET_TWO_RST;
			sleep_temp_q  <= SLEEP_TEMP_RST;
			sleep_delay_q <= SLEEP_DELAY_RST;
			off_delay_q   <= OFF_DELAY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_GAIN:        gain_q        <= cfg.data;
				REG_PRESET_ONE:  preset_one_q  <= cfg.data[CELSIUS_W-1:0];
				REG_PRESET_TWO:  preset_two_q  <= cfg.data[CELSIUS_W-1:0];
				REG_SLEEP_TEMP:  sleep_temp_q  <= cfg.data[CELSIUS_W-1:0];
				REG_SLEEP_DELAY: sleep_delay_q <= cfg.data;
				REG_OFF_DELAY:   off_delay_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			mode_q              <= MODE_MANUAL;
			mode_before_sleep_q <= MODE_MANUAL;
			idle_q              <= '0;
			div_q               <= '0;
			manual_q            <= MANUAL_RST;
			last_good_q         <= '0;
			iron_q              <= 1'b0;
			boost_q             <= 1'b0;
			motion_q            <= 1'b0;
			target_adc_q        <= '0;
			target_cel_q        <= '0;
			restart_q           <= 1'b0;
			post_wake_q         <= 1'b0;
			req_q               <= '0;
			out_valid_q         <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_in.valid) begin
						op_q    <= item_in.op;
						level_q <= item_in.motion_level;
						value_q <= item_in.manual_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					restart_q   <= 1'b0;
					post_wake_q <= 1'b0;
					state_q     <= S_FINISH;
					req_q.boost <= boost_q;
					case (op_q)
						OP_TICK: begin
							if (tick_roll) begin
								div_q <= '0;
								if (iron_q) begin
									idle_q <= idle_inc;
									if (hit_sleep) begin
										mode_before_sleep_q <= mode_q;
										mode_q              <= MODE_SLEEP;
										req_q.start         <= 1'b1;
										req_q.celsius       <= sleep_temp_q;
										state_q             <= S_APPLY;
									end
								end
							end else begin
								div_q <= div_q + 1'b1;
							end
						end
						OP_ON: begin
							idle_q        <= '0;
							mode_q        <= wake_mode;
							iron_q        <= 1'b1;
							req_q.start   <= 1'b1;
							req_q.celsius <= temp_for(wake_mode, manual_q, preset_one_q,
								preset_two_q, sleep_temp_q);
							state_q       <= S_APPLY;
						end
						OP_MANUAL: begin
							if (manual_diff) begin
								idle_q        <= '0;
								mode_q        <= MODE_MANUAL;
								req_q.start   <= 1'b1;
								req_q.celsius <= manual_q;
								state_q       <= S_APPLY;
							end
						end
						OP_PRESET1: begin
							idle_q        <= '0;
							mode_q        <= MODE_PRESET1;
							req_q.start   <= 1'b1;
							req_q.celsius <= preset_one_q;
							state_q       <= S_APPLY;
						end
						OP_PRESET2: begin
							idle_q        <= '0;
							mode_q        <= MODE_PRESET2;
							req_q.start   <= 1'b1;
							req_q.celsius <= preset_two_q;
							state_q       <= S_APPLY;
						end
						OP_BOOST_ON, OP_BOOST_OFF: begin
							// The setpoint follows the mode held before the wake,
							// so a sleeping iron keeps the sleep setpoint.
							boost_q       <= (op_q == OP_BOOST_ON);
							idle_q        <= '0;
							post_wake_q   <= 1'b1;
							req_q.start   <= 1'b1;
							req_q.boost   <= (op_q == OP_BOOST_ON);
							req_q.celsius <= temp_for(mode_q, manual_q, preset_one_q,
								preset_two_q, sleep_temp_q);
							state_q       <= S_APPLY;
						end
						OP_MOTION: begin
							if (level_q != motion_q) begin
								idle_q        <= '0;
								mode_q        <= wake_mode;
								req_q.start   <= 1'b1;
								req_q.celsius <= temp_for(wake_mode, manual_q, preset_one_q,
									preset_two_q, sleep_temp_q);
								state_q       <= S_APPLY;
							end
							motion_q <= level_q;
						end
						OP_WRITE_MANUAL: begin
							manual_q <= value_q;
						end
						default: begin
						end
					endcase
					// Turn-off, by command or by the idle timeout.
					if (off_now) begin
						iron_q    <= 1'b0;
						restart_q <= 1'b1;
						idle_q    <= '0;
						if (manual_diff) begin
							mode_q        <= MODE_MANUAL;
							req_q.start   <= 1'b1;
							req_q.celsius <= manual_q;
							state_q       <= S_APPLY;
						end else begin
							mode_q <= wake_mode;
						end
					end
				end
				S_APPLY: begin
					if (rsp.done) begin
						target_adc_q <= rsp.adc;
						target_cel_q <= rsp.celsius;
						if (!boost_q) begin
							if (rsp.clamped) begin
								if (mode_q == MODE_MANUAL) begin
									manual_q <= last_good_q;
								end
							end else begin
								last_good_q <= manual_q;
							end
						end
						if (post_wake_q && (mode_q == MODE_SLEEP)) begin
							mode_q <= mode_before_sleep_q;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q   <= 1'b1;
						out_adc_q     <= target_adc_q;
						out_cel_q     <= target_cel_q;
						out_mode_q    <= mode_q;
						out_heater_q  <= iron_q;
						out_boost_q   <= boost_q;
						out_restart_q <= restart_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_in.ready                 = (state_q == S_IDLE);
	assign result_out.valid              = out_valid_q;
	assign result_out.setpoint_adc       = out_adc_q;
	assign result_out.setpoint_celsius   = out_cel_q;
	assign result_out.active_mode        = out_mode_q;
	assign result_out.heater_enabled     = out_heater_q;
	assign result_out.boost_active       = out_boost_q;
	assign result_out.controller_restart = out_restart_q;

endmodule

### sim/heater_sleep_and_mode_supervisor_tb.sv
`timescale 1ns / 1ps

module heater_sleep_and_mode_supervisor_tb;
	import hsms_pkg::*;

	localparam logic [31:0] ADC_LIMIT   = ADC_MAX_DEF;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          LONG_HOLD   = 90;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 175;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic                 level;
		logic [CELSIUS_W-1:0] value;
	} user_action_t;

	typedef struct packed {
		logic [SETPOINT_W-1:0] adc;
		logic [CELSIUS_W-1:0]  celsius;
		logic [MODE_W-1:0]     mode;
		logic                  heater;
		logic                  boost;
		logic                  restart;
	} heater_status_t;

	logic clk;
	logic arst_n;

	hsms_item_if   item_if();
	hsms_result_if result_if();
	hsms_cfg_if    cfg_if();

	heater_sleep_and_mode_supervisor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_if),
		.item_in   (item_if),
		.result_out(result_if)
	);

	// Register copies and supervisor state of the predictor.
	logic [GAIN_W-1:0]    cfg_gain;
	logic [CELSIUS_W-1:0] cfg_preset_one, cfg_preset_two, cfg_sleep_temp;
	logic [DELAY_W-1:0]   cfg_sleep_delay, cfg_off_delay;

	logic [MODE_W-1:0]     mode_now, mode_prior;
	logic [DELAY_W-1:0]    idle_units;
	logic [3:0]            tick_phase;
	logic [CELSIUS_W-1:0]  manual_temp, last_safe_manual;
	logic                  iron_on, boost_on, motion_last;
	logic [SETPOINT_W-1:0] target_adc;
	logic [CELSIUS_W-1:0]  target_celsius;

	user_action_t   user_actions[$];
	heater_status_t awaited_status[$];

	int  queued_count, accepted_count, mismatches, cycle_count;
	int  source_gap, sink_gap, hold_left;
	bit  item_sent, cfg_written, quiet_phase, hold_receiver;

	always #10 clk = ~clk;

	function automatic void load_setpoint(input logic [MODE_W-1:0] mode);
		logic [CELSIUS_W-1:0] celsius;
		logic [31:0]          scaled;
		mode_now = mode;
		if (boost_on) begin
			target_adc = ADC_LIMIT[SETPOINT_W-1:0];
			if (cfg_gain == '0) begin
				target_celsius = 10'd1023;
			end else begin
				scaled = (ADC_LIMIT << GAIN_FRAC_W) / 32'(cfg_gain);
				target_celsius = (scaled > 32'd1023) ? 10'd1023 : scaled[CELSIUS_W-1:0];
			end
		end else begin
			case (mode)
				MODE_MANUAL:  celsius = manual_temp;
				MODE_PRESET1: celsius = cfg_preset_one;
				MODE_PRESET2: celsius = cfg_preset_two;
				default:      celsius = cfg_sleep_temp;
			endcase
			target_celsius = celsius;
			// Half a degree is added before scaling, hence the extra fraction bit.
			scaled = (((32'(celsius) << 1) + 32'd1) * 32'(cfg_gain)) >> FRAC_SHIFT;
			if (scaled >= ADC_LIMIT) begin
				target_adc = ADC_LIMIT[SETPOINT_W-1:0];
				if (mode == MODE_MANUAL)
					manual_temp = last_safe_manual;
			end else begin
				target_adc = scaled[SETPOINT_W-1:0];
				last_safe_manual = manual_temp;
			end
		end
	endfunction

	function automatic void wake_up();
		if (mode_now == MODE_SLEEP)
			mode_now = mode_prior;
		idle_units = '0;
	endfunction

	function automatic void resume_manual();
		if (last_safe_manual != manual_temp) begin
			load_setpoint(MODE_MANUAL);
			wake_up();
		end
	endfunction

	function automatic void power_down();
		iron_on = 1'b0;
		wake_up();
		resume_manual();
	endfunction

	function automatic heater_status_t supervise_step(input user_action_t act);
		heater_status_t st;
		logic           restart;
		logic [DELAY_W-1:0] old_idle;
		restart = 1'b0;
		case (act.op)
			OP_TICK: begin
				if (32'(tick_phase) + 32'd1 >= TICKS_PER_COUNT_DEF) begin
					tick_phase = '0;
					if (iron_on) begin
						old_idle = idle_units;
						idle_units = idle_units + 1'b1;
						if (old_idle == cfg_sleep_delay) begin
							mode_prior = mode_now;
							load_setpoint(MODE_SLEEP);
						end else if ({1'b0, idle_units} ==
								{1'b0, cfg_sleep_delay} + {1'b0, cfg_off_delay}) begin
							power_down();
							restart = 1'b1;
						end
					end
				end else begin
					tick_phase = tick_phase + 1'b1;
				end
			end
			OP_ON: begin
				wake_up();
				load_setpoint(mode_now);
				iron_on = 1'b1;
			end
			OP_OFF: begin
				power_down();
				restart = 1'b1;
			end
			OP_MANUAL: resume_manual();
			OP_PRESET1: begin
				load_setpoint(MODE_PRESET1);
				wake_up();
			end
			OP_PRESET2: begin
				load_setpoint(MODE_PRESET2);
				wake_up();
			end
			OP_BOOST_ON, OP_BOOST_OFF: begin
				boost_on = (act.op == OP_BOOST_ON);
				load_setpoint(mode_now);
				wake_up();
			end
			OP_MOTION: begin
				if (act.level != motion_last) begin
					wake_up();
					load_setpoint(mode_now);
				end
				motion_last = act.level;
			end
			OP_WRITE_MANUAL: manual_temp = act.value;
			default: ;
		endcase
		st.adc     = target_adc;
		st.celsius = target_celsius;
		st.mode    = mode_now;
		st.heater  = iron_on;
		st.boost   = boost_on;
		st.restart = restart;
		return st;
	endfunction

	function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GAIN:        cfg_gain        = data;
			REG_PRESET_ONE:  cfg_preset_one  = data[CELSIUS_W-1:0];
			REG_PRESET_TWO:  cfg_preset_two  = data[CELSIUS_W-1:0];
			REG_SLEEP_TEMP:  cfg_sleep_temp  = data[CELSIUS_W-1:0];
			REG_SLEEP_DELAY: cfg_sleep_delay = data;
			REG_OFF_DELAY:   cfg_off_delay   = data;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at cycle %0d: %0s got %0d, expected %0d",
			cycle_count, what, got, want);
		mismatches++;
	endtask

	task automatic check_status(input heater_status_t got);
		heater_status_t want;
		if (awaited_status.size() == 0) begin
			report_mismatch("result with nothing pending", 32'd1, 32'd0);
		end else begin
			want = awaited_status.pop_front();
			if (got.adc != want.adc)
				report_mismatch("setpoint_adc", 32'(got.adc), 32'(want.adc));
			if (got.celsius != want.celsius)
				report_mismatch("setpoint_celsius", 32'(got.celsius), 32'(want.celsius));
			if (got.mode != want.mode)
				report_mismatch("active_mode", 32'(got.mode), 32'(want.mode));
			if (got.heater != want.heater)
				report_mismatch("heater_enabled", 32'(got.heater), 32'(want.heater));
			if (got.boost != want.boost)
				report_mismatch("boost_active", 32'(got.boost), 32'(want.boost));
			if (got.restart != want.restart)
				report_mismatch("controller_restart", 32'(got.restart), 32'(want.restart));
		end
	endtask

	// Monitor: every transfer is seen at the rising edge.
	always @(posedge clk) begin : monitor
		heater_status_t got;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				store_register(cfg_if.index, cfg_if.data);
				cfg_written = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				got.adc     = result_if.setpoint_adc;
				got.celsius = result_if.setpoint_celsius;
				got.mode    = result_if.active_mode;
				got.heater  = result_if.heater_enabled;
				got.boost   = result_if.boost_active;
				got.restart = result_if.controller_restart;
				check_status(got);
			end
			if (item_if.valid && item_if.ready) begin
				awaited_status.push_back(supervise_step('{item_if.op, item_if.motion_level,
					item_if.manual_value}));
				accepted_count++;
				item_sent = 1'b1;
			end
		end
	end

	// Event driver with random bursts of idle cycles.
	always @(negedge clk) begin : sender
		user_action_t act;
		if (arst_n && (!item_if.valid || item_sent)) begin
			item_sent = 1'b0;
			if (source_gap != 0) begin
				source_gap--;
				item_if.valid <= 1'b0;
			end else if (user_actions.size() != 0 && !quiet_phase &&
					$urandom_range(0, 5) == 0) begin
				source_gap = $urandom_range(0, 6);
				item_if.valid <= 1'b0;
			end else if (user_actions.size() != 0) begin
				act = user_actions.pop_front();
				item_if.valid        <= 1'b1;
				item_if.op           <= act.op;
				item_if.motion_level <= act.level;
				item_if.manual_value <= act.value;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold that backs up the block.
	always @(negedge clk) begin : receiver
		if (hold_receiver) begin
			hold_receiver = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else if (sink_gap != 0) begin
			sink_gap--;
			result_if.ready <= 1'b0;
		end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			sink_gap = $urandom_range(0, 6);
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_action(input logic [OP_W-1:0] op, input logic level,
			input logic [CELSIUS_W-1:0] value);
		user_actions.push_back('{op, level, value});
		queued_count++;
	endtask

	task automatic queue_random_action();
		int unsigned pick;
		logic [CELSIUS_W-1:0] value;
		logic [OP_W-1:0] op;
		pick = $urandom_range(0, 99);
		value = CELSIUS_W'($urandom_range(0, 1023));
		if (pick < 40)      op = OP_TICK;
		else if (pick < 48) op = OP_ON;
		else if (pick < 53) op = OP_OFF;
		else if (pick < 59) op = OP_MANUAL;
		else if (pick < 64) op = OP_PRESET1;
		else if (pick < 69) op = OP_PRESET2;
		else if (pick < 74) op = OP_BOOST_ON;
		else if (pick < 79) op = OP_BOOST_OFF;
		else if (pick < 87) op = OP_MOTION;
		else if (pick < 95) begin
			op = OP_WRITE_MANUAL;
			// Keep many manual values low enough to avoid the clamp.
			if ($urandom_range(0, 1) == 0)
				value = CELSIUS_W'($urandom_range(0, 300));
		end else begin
			op = OP_W'(32'(OP_WRITE_MANUAL) + 32'd1 + $urandom_range(0, 5));
		end
		queue_action(op, 1'($urandom_range(0, 1)), value);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_written = 1'b0;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do
			@(negedge clk);
		while (!cfg_written);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic drain();
		while (accepted_count != queued_count || awaited_status.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		logic [GAIN_W-1:0]    gain;
		logic [CELSIUS_W-1:0] preset_one, preset_two, sleep_c;
		logic [DELAY_W-1:0]   sleep_d, off_d;
		int                   phase_start;

		clk = 1'b0;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.op = OP_TICK;
		item_if.motion_level = 1'b0;
		item_if.manual_value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_GAIN;
		cfg_if.data = '0;
		result_if.ready = 1'b0;

		cfg_gain = GAIN_RST;
		cfg_preset_one = PRESET_ONE_RST;
		cfg_preset_two = PRESET_TWO_RST;
		cfg_sleep_temp = SLEEP_TEMP_RST;
		cfg_sleep_delay = SLEEP_DELAY_RST;
		cfg_off_delay = OFF_DELAY_RST;
		mode_now = MODE_MANUAL;
		mode_prior = MODE_MANUAL;
		idle_units = '0;
		tick_phase = '0;
		manual_temp = MANUAL_RST;
		last_safe_manual = '0;
		iron_on = 1'b0;
		boost_on = 1'b0;
		motion_last = 1'b0;
		target_adc = '0;
		target_celsius = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed events under the reset register values.
		queue_action(OP_TICK, 1'b1, 10'd1023);
		queue_action(OP_MOTION, 1'b1, 10'd0);
		queue_action(OP_MOTION, 1'b1, 10'd1023);
		queue_action(OP_WRITE_MANUAL, 1'b0, 10'd1023);
		queue_action(OP_MANUAL, 1'b0, 10'd0);        // too hot: old manual value returns
		queue_action(OP_WRITE_MANUAL, 1'b1, 10'd0);
		queue_action(OP_MANUAL, 1'b1, 10'd1023);
		queue_action(OP_ON, 1'b0, 10'd512);
		queue_action(OP_PRESET1, 1'b1, 10'd511);
		queue_action(OP_PRESET2, 1'b0, 10'd341);
		queue_action(OP_BOOST_ON, 1'b1, 10'd682);
		queue_action(OP_PRESET1, 1'b0, 10'd1);
		queue_action(OP_BOOST_OFF, 1'b1, 10'd2);
		queue_action(OP_MOTION, 1'b0, 10'd4);
		queue_action(OP_WRITE_MANUAL, 1'b1, 10'd511);
		queue_action(OP_MANUAL, 1'b0, 10'd8);
		queue_action(OP_WRITE_MANUAL, 1'b1, 10'd512);
		queue_action(OP_MANUAL, 1'b0, 10'd16);
		queue_action(OP_OFF, 1'b1, 10'd32);
		queue_action(OP_WRITE_MANUAL + 4'd1, 1'b1, 10'd64);
		queue_action(OP_WRITE_MANUAL + 4'd6, 1'b0, 10'd128);
		queue_action(OP_WRITE_MANUAL, 1'b1, 10'd1023);
		queue_action(OP_OFF, 1'b0, 10'd256);           // off with a manual value that clamps
		queue_action(OP_TICK, 1'b1, 10'd0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			gain = GAIN_W'($urandom_range(1024, 16384));
			preset_one = CELSIUS_W'($urandom_range(0, 1023));
			preset_two = CELSIUS_W'($urandom_range(0, 600));
			sleep_c = CELSIUS_W'($urandom_range(0, 400));
			sleep_d = DELAY_W'($urandom_range(0, 4));
			off_d = DELAY_W'($urandom_range(0, 6));
			case (phase)
				0: begin
					gain = 16'd1;
					preset_one = 10'd0;
					preset_two = 10'd1023;
					sleep_c = 10'd0;
					sleep_d = 16'd0;
					off_d = 16'd2;
				end
				1: begin
					gain = 16'hFFFF;
					sleep_c = 10'd1023;
					sleep_d = 16'd1;
					off_d = 16'd0;
				end
				2: begin
					// A zero gain leaves only the boost path with a nonzero target.
					gain = 16'd0;
					sleep_d = 16'd2;
					off_d = 16'd1;
				end
				3: begin
					sleep_d = 16'hFFFF;
					off_d = 16'hFFFF;
				end
				4: begin
					gain = 16'd4096;
					sleep_d = 16'd0;
					off_d = 16'd0;
				end
				default: ;
			endcase
			if (phase == PHASES - 1)
				quiet_phase = 1'b1;

			write_register(REG_GAIN, gain);
			write_register(REG_PRESET_ONE, {6'($urandom), preset_one});
			write_register(REG_PRESET_TWO, {6'($urandom), preset_two});
			write_register(REG_SLEEP_TEMP, {6'($urandom), sleep_c});
			write_register(REG_SLEEP_DELAY, sleep_d);
			write_register(REG_OFF_DELAY, off_d);
			// Indexes past the last register must not disturb anything.
			write_register(CFG_IDX_W'(32'(REG_OFF_DELAY) + 32'd1 + $urandom_range(0, 1)),
				16'($urandom));

			phase_start = queued_count;
			while (queued_count - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 6) begin
					// Power up and let the idle timer run toward sleep and turn-off.
					queue_action(OP_ON, 1'($urandom_range(0, 1)),
						CELSIUS_W'($urandom_range(0, 1023)));
					repeat ($urandom_range(11, 132)) begin
						if ($urandom_range(0, 24) == 0)
							queue_random_action();
						else
							queue_action(OP_TICK, 1'($urandom_range(0, 1)),
								CELSIUS_W'($urandom_range(0, 1023)));
					end
				end else begin
					queue_random_action();
				end
			end
			if (phase == 4)
				hold_receiver = 1'b1;
			drain();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
